### rtl/core/srfp_pkg.sv
`timescale 1ns / 1ps

package srfp_pkg;

    // Payload buffer sizing.
    localparam int MAX_PAYLOAD_WORDS = 8;
    localparam int IDX_W             = $clog2(MAX_PAYLOAD_WORDS);
    localparam int POS_W             = $clog2(MAX_PAYLOAD_WORDS + 1);
    localparam int COUNT_W           = 4;
    localparam int WIDX_W            = 3;

    // Head bytes.
    localparam logic [7:0] HEAD_OK    = 8'hAA;
    localparam logic [7:0] HEAD_FAULT = 8'hEE;

    // Configuration register indexes.
    localparam logic CFG_MATCH_ENABLE = 1'b0;
    localparam logic CFG_MATCH_REG    = 1'b1;
    localparam logic [15:0] MATCH_REG_RESET = 16'd34;

    // Header byte positions after the head byte.
    localparam logic [2:0] HDR_ADDR     = 3'd0;
    localparam logic [2:0] HDR_REG_HI   = 3'd1;
    localparam logic [2:0] HDR_REG_LO   = 3'd2;
    localparam logic [2:0] HDR_COUNT_HI = 3'd3;
    localparam logic [2:0] HDR_COUNT_LO = 3'd4;

    typedef enum logic [2:0] {
        S_HUNT,
        S_HEADER,
        S_PAY_HI,
        S_PAY_LO,
        S_CHECK,
        S_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic head;       // head byte seen: latch kind, clear sum and header index
        logic hdr_step;   // header byte
        logic pay_hi;     // payload high byte
        logic pay_lo;     // payload low byte, write buffer
        logic abort;      // deadline: clear header index
        logic emit_start; // checksum passed: rewind read index
        logic emit_load;  // load one word into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_head;
        logic hdr_last;
        logic count_ok;
        logic words_done;
        logic frame_pass;
        logic emit_last;
        logic out_free;
    } t_status;

endpackage

### rtl/core/srfp_ctrl.sv
`timescale 1ns / 1ps

module srfp_ctrl
    import srfp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_func,
    input  t_status i_status,
    output logic    o_in_stall,
    output t_cmd    o_cmd,
    output t_state  o_state
);

    t_state r_state;
    t_state n_state;
    logic   accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HUNT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state == S_EMIT);
    assign accept     = i_in_valid && !o_in_stall;
    assign o_state    = r_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        if (r_state == S_EMIT) begin
            if (i_status.out_free) begin
                o_cmd.emit_load = 1'b1;
                if (i_status.emit_last) begin
                    n_state = S_HUNT;
                end
            end
        end else if (accept && i_func) begin
            o_cmd.abort = 1'b1;
            n_state     = S_HUNT;
        end else if (accept) begin
            case (r_state)
                S_HUNT: begin
                    if (i_status.is_head) begin
                        o_cmd.head = 1'b1;
                        n_state    = S_HEADER;
                    end
                end
                S_HEADER: begin
                    o_cmd.hdr_step = 1'b1;
                    if (i_status.hdr_last) begin
                        n_state = i_status.count_ok ? S_PAY_HI : S_HUNT;
                    end
                end
                S_PAY_HI: begin
                    o_cmd.pay_hi = 1'b1;
                    n_state      = S_PAY_LO;
                end
                S_PAY_LO: begin
                    o_cmd.pay_lo = 1'b1;
                    n_state      = i_status.words_done ? S_CHECK : S_PAY_HI;
                end
                S_CHECK: begin
                    if (i_status.frame_pass) begin
                        o_cmd.emit_start = 1'b1;
                        n_state          = S_EMIT;
                    end else begin
                        n_state = S_HUNT;
                    end
                end
                default: begin
                    n_state = S_HUNT;
                end
            endcase
        end
    end

endmodule

### rtl/core/srfp_dp.sv
`timescale 1ns / 1ps

module srfp_dp
    import srfp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    input  logic [7:0]          i_rx_byte,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [15:0]         i_cfg_data,
    input  logic                i_out_stall,
    output t_status             o_status,
    output logic                o_out_valid,
    output logic                o_is_error,
    output logic [7:0]          o_device_addr,
    output logic [15:0]         o_reg_addr,
    output logic [COUNT_W-1:0]  o_word_count,
    output logic [WIDX_W-1:0]   o_word_index,
    output logic [15:0]         o_word_value,
    output logic                o_last
);

    logic               r_match_enable;
    logic [15:0]        r_match_reg;
    logic [2:0]         r_hdr_idx;
    logic               r_err_frame;
    logic [7:0]         r_frame_addr;
    logic [15:0]        r_frame_reg;
    logic [COUNT_W-1:0] r_frame_words;
    logic [POS_W-1:0]   r_word_pos;
    logic [7:0]         r_hold;
    logic [7:0]         r_sum;
    logic [IDX_W-1:0]   r_emit_idx;
    logic [15:0]        r_store [MAX_PAYLOAD_WORDS];
    logic               r_out_valid;
    logic [7:0]         sum_next;
    logic [COUNT_W-1:0] emit_next;
    logic [POS_W-1:0]   pos_next;

    assign sum_next  = r_sum + i_rx_byte;
    assign emit_next = COUNT_W'(r_emit_idx) + COUNT_W'(1);
    assign pos_next  = r_word_pos + POS_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_enable <= 1'b0;
            r_match_reg    <= MATCH_REG_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_MATCH_ENABLE) begin
                r_match_enable <= i_cfg_data[0];
            end else begin
                r_match_reg <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_idx <= HDR_ADDR;
        end else if (i_cmd.head || i_cmd.abort) begin
            r_hdr_idx <= HDR_ADDR;
        end else if (i_cmd.hdr_step) begin
            r_hdr_idx <= (r_hdr_idx == HDR_COUNT_LO) ? HDR_ADDR : r_hdr_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.head) begin
            r_err_frame <= (i_rx_byte == HEAD_FAULT);
            r_sum       <= '0;
        end
        if (i_cmd.hdr_step || i_cmd.pay_hi || i_cmd.pay_lo) begin
            r_sum <= sum_next;
        end
        if (i_cmd.hdr_step) begin
            case (r_hdr_idx)
                HDR_ADDR:     r_frame_addr       <= i_rx_byte;
                HDR_REG_HI:   r_frame_reg        <= {i_rx_byte, 8'h00};
                HDR_REG_LO:   r_frame_reg[7:0]   <= i_rx_byte;
                HDR_COUNT_HI: r_hold             <= i_rx_byte;
                default: begin
                    // The count is only used after it passed the plausibility check.
                    r_frame_words <= i_rx_byte[COUNT_W-1:0];
                    r_word_pos    <= '0;
                end
            endcase
        end
        if (i_cmd.pay_hi) begin
            r_hold <= i_rx_byte;
        end
        if (i_cmd.pay_lo) begin
            r_store[r_word_pos[IDX_W-1:0]] <= {r_hold, i_rx_byte};
            r_word_pos                     <= pos_next;
        end
        if (i_cmd.emit_start) begin
            r_emit_idx <= '0;
        end
        if (i_cmd.emit_load) begin
            r_emit_idx <= r_emit_idx + IDX_W'(1);
        end
    end

    // Output register: holds a full snapshot, so the next frame may start
    // while the final word still waits downstream.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_load) begin
            o_is_error    <= r_err_frame;
            o_device_addr <= r_frame_addr;
            o_reg_addr    <= r_frame_reg;
            o_word_count  <= r_frame_words;
            o_word_index  <= WIDX_W'(r_emit_idx);
            o_word_value  <= r_store[r_emit_idx];
            o_last        <= (emit_next == r_frame_words);
        end
    end

    assign o_out_valid = r_out_valid;

    always_comb begin
        o_status.is_head    = (i_rx_byte == HEAD_OK) || (i_rx_byte == HEAD_FAULT);
        o_status.hdr_last   = (r_hdr_idx == HDR_COUNT_LO);
        o_status.count_ok   = (r_hold == 8'h00) && (i_rx_byte != 8'h00)
                              && (i_rx_byte <= 8'(MAX_PAYLOAD_WORDS));
        o_status.words_done = (COUNT_W'(pos_next) >= r_frame_words);
        o_status.frame_pass = (i_rx_byte == r_sum)
                              && (r_err_frame || !r_match_enable
                                  || (r_frame_reg == r_match_reg));
        o_status.emit_last  = (emit_next == r_frame_words);
        o_status.out_free   = !r_out_valid || !i_out_stall;
    end

endmodule

### rtl/core/sensor_reply_frame_parser.sv
`timescale 1ns / 1ps

// Sensor reply frame parser. Each input word is either a received serial byte
// (i_func low) or a deadline notice (i_func high) that abandons any partial
// frame. The parser hunts for a head byte, 0xAA for an ok reply or 0xEE for an
// error reply, reads the five header bytes (address, 16-bit register and
// 16-bit word count, high byte first), buffers up to eight payload words and
// checks the modulo-256 sum of every byte after the head against the checksum
// byte. A good frame is delivered as a run of output words, one per payload
// word, with the header fields repeated on each and o_last marking the final
// one; a bad checksum, an implausible count or the optional register filter
// drops the frame without any output. Error frames always pass the filter.
// An input word is taken whenever o_in_stall is low. After a passing checksum
// byte the parser drains the buffer into the output register, one word per
// cycle while the output side is not stalled, and holds the input off until
// the drain is done; o_in_stall is high during that drain. The final word
// sits in its own output register, so the next frame can begin while it
// waits. Configuration (index 0: match enable, index 1: match register,
// reset 34) should be written only while the parser is idle.

module sensor_reply_frame_parser
    import srfp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [15:0]         i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_func,
    input  logic [7:0]          i_rx_byte,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_is_error,
    output logic [7:0]          o_device_addr,
    output logic [15:0]         o_reg_addr,
    output logic [COUNT_W-1:0]  o_word_count,
    output logic [WIDX_W-1:0]   o_word_index,
    output logic [15:0]         o_word_value,
    output logic                o_last
);

    t_cmd    cmd;
    t_status status;
    t_state  state;

    // The controller sequences the frame; the datapath holds every field.
    srfp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_func),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd),
        .o_state    (state)
    );

    srfp_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_rx_byte     (i_rx_byte),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_out_stall   (i_out_stall),
        .o_status      (status),
        .o_out_valid   (o_out_valid),
        .o_is_error    (o_is_error),
        .o_device_addr (o_device_addr),
        .o_reg_addr    (o_reg_addr),
        .o_word_count  (o_word_count),
        .o_word_index  (o_word_index),
        .o_word_value  (o_word_value),
        .o_last        (o_last)
    );

`ifndef NO_ASSERTIONS
    // A word on the output always lies inside its frame.
    a_index_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_word_count != '0) && (COUNT_W'(o_word_index) < o_word_count))
        else $error("output word index outside its frame");

    // The last flag marks exactly the final word of the run.
    a_last_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last == (COUNT_W'(o_word_index) + COUNT_W'(1) == o_word_count)))
        else $error("last flag on the wrong word");

    // Within a run, a taken word is followed at once by the next one.
    a_run_unbroken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_last |=> o_out_valid)
        else $error("gap inside an output run");

    // No input word is taken while a frame is draining.
    a_drain_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (state == S_EMIT) |-> o_in_stall && !cmd.head && !cmd.hdr_step && !cmd.pay_lo)
        else $error("input consumed during drain");
`endif

endmodule
